FILE: src/epc_pkg.sv
// ----------------------------------------------------------------------------
// epc_pkg
// Shared constants, register codes and datapath types of the encoder PID
// position controller.
// ----------------------------------------------------------------------------
package epc_pkg;

  localparam int GAIN_FRAC_BITS = 8;
  localparam int POSITION_BITS  = 32;

  localparam int GAIN_W     = 16;
  localparam int TARGET_W   = 32;
  localparam int ERR_W      = 32;
  localparam int DERIV_W    = ERR_W + 1;
  localparam int SUM_W      = 48;
  localparam int SUM_LO_W   = 24;
  localparam int SUM_HI_W   = SUM_W - SUM_LO_W;
  localparam int ACC_W      = 64;
  localparam int DUTY_W     = 8;
  localparam int DUTY_MAX   = 255;
  localparam int OUT_W      = 32;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int IN_TDATA_W    = 8;
  localparam int IN_TUSER_W    = 1;
  localparam int OUT_FIELDS_W  = DUTY_W + 1 + OUT_W + OUT_W;
  localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P = 2'd0,
    REG_GAIN_I = 2'd1,
    REG_GAIN_D = 2'd2,
    REG_TARGET = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
  } epc_gains_t;

  // Partial products of one control tick; the integral term is split in a
  // low unsigned half and a high signed half of the error sum.
  typedef struct packed {
    logic signed [GAIN_W+ERR_W-1:0]    p;
    logic signed [GAIN_W+DERIV_W-1:0]  d;
    logic signed [GAIN_W+SUM_LO_W:0]   i_lo;
    logic signed [GAIN_W+SUM_HI_W-1:0] i_hi;
  } epc_prod_t;

endpackage

FILE: src/epc_product_stage.sv
// ----------------------------------------------------------------------------
// epc_product_stage
// Registered gain multipliers: proportional, derivative and the two halves
// of the integral product.
// ----------------------------------------------------------------------------
module epc_product_stage (
  input  logic                                    clk_i,
  input  logic                                    en_i,
  input  epc_pkg::epc_gains_t                     gains_i,
  input  logic signed [epc_pkg::ERR_W-1:0]        err_i,
  input  logic signed [epc_pkg::DERIV_W-1:0]      deriv_i,
  input  logic signed [epc_pkg::SUM_W-1:0]        sum_i,
  output epc_pkg::epc_prod_t                      prod_o
);
  import epc_pkg::*;

  epc_prod_t prod_q;

  logic signed [SUM_LO_W:0]   sum_lo;
  logic signed [SUM_HI_W-1:0] sum_hi;

  // low half is unsigned: prepend a zero sign bit
  assign sum_lo = $signed({1'b0, sum_i[SUM_LO_W-1:0]});
  assign sum_hi = $signed(sum_i[SUM_W-1:SUM_LO_W]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q.p    <= gains_i.kp * err_i;
      prod_q.d    <= gains_i.kd * deriv_i;
      prod_q.i_lo <= gains_i.ki * sum_lo;
      prod_q.i_hi <= gains_i.ki * sum_hi;
    end
  end

  assign prod_o = prod_q;

endmodule

FILE: src/encoder_pid_position_controller.sv
// ----------------------------------------------------------------------------
// encoder_pid_position_controller
// Encoder position counter with a pipelined PID loop that turns each control
// tick into a motor direction and PWM duty.
// ----------------------------------------------------------------------------
// The block takes one input transaction per cycle while s_axis_tready is
// high. An encoder edge (tuser = 0) moves the position counter up or down at
// the clock edge that accepts it and produces no output. A control tick
// (tuser = 1) samples the position and target, and its result passes through
// the registered stages ERR, SUM, PROD, PART, ACC and OUT before it is valid
// on the master side; ticks may follow each other back to back. The sustained
// rate of one item per cycle is set by the error-sum accumulator, which takes
// one add and saturate per cycle; the multiplies and the final sum run in the
// following stages and never feed back. The input side stalls only when all
// six stages hold ticks and the output is not being taken. Gains and target
// should be written while no tick is in flight.
// ----------------------------------------------------------------------------
module encoder_pid_position_controller (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration
  input  logic                                  cfg_we_i,
  input  logic [epc_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [epc_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  // input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [epc_pkg::IN_TDATA_W-1:0]        s_axis_tdata,  // [0] enc_b, rest zero
  input  logic [epc_pkg::IN_TUSER_W-1:0]        s_axis_tuser,  // [0] kind
  // result stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [7:0] pwm_duty, [8] drive_forward, [40:9] position_now,
  // [72:41] control_value, rest zero
  output logic [epc_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);
  import epc_pkg::*;

  // pipeline stage numbering
  localparam int STG_ERR  = 0;  // error sampled
  localparam int STG_SUM  = 1;  // integral updated, derivative formed
  localparam int STG_PROD = 2;  // gain products
  localparam int STG_PART = 3;  // pairwise sums
  localparam int STG_ACC  = 4;  // full accumulator
  localparam int STG_OUT  = 5;  // scaled, saturated result
  localparam int NUM_STG  = 6;

  localparam int DIFF_W = ((POSITION_BITS > TARGET_W) ? POSITION_BITS : TARGET_W) + 1;

  localparam logic signed [DIFF_W-1:0] ERR_HI = DIFF_W'(2147483647);
  localparam logic signed [DIFF_W-1:0] ERR_LO = -ERR_HI - DIFF_W'(1);
  localparam logic signed [SUM_W:0]    SUM_HI = (SUM_W+1)'((64'(1) << (SUM_W - 1)) - 64'(1));
  localparam logic signed [SUM_W:0]    SUM_LO = -SUM_HI - (SUM_W+1)'(1);
  localparam logic signed [ACC_W-1:0]  CTRL_HI = ACC_W'(2147483647);
  localparam logic signed [ACC_W-1:0]  CTRL_LO = -CTRL_HI - ACC_W'(1);
  localparam logic signed [ACC_W-1:0]  DUTY_HI = ACC_W'(DUTY_MAX);
  localparam logic [ACC_W-1:0]         FRAC_MASK = (ACC_W'(1) << GAIN_FRAC_BITS) - ACC_W'(1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  epc_gains_t                  gains_q;
  logic signed [TARGET_W-1:0]  target_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q.kp <= GAIN_W'(256);
      gains_q.ki <= '0;
      gains_q.kd <= '0;
      target_q   <= TARGET_W'(90);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_GAIN_P: gains_q.kp <= cfg_data_i[GAIN_W-1:0];
        REG_GAIN_I: gains_q.ki <= cfg_data_i[GAIN_W-1:0];
        REG_GAIN_D: gains_q.kd <= cfg_data_i[GAIN_W-1:0];
        REG_TARGET: target_q   <= cfg_data_i[TARGET_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake and stage valids
  // --------------------------------------------------------------------------
  logic [NUM_STG-1:0] vld_q, vld_d, rdy, nxt_rdy, load;
  logic               s_fire, tick_fire, edge_fire;

  always_comb begin
    rdy[NUM_STG-1]     = !vld_q[NUM_STG-1] || m_axis_tready;
    nxt_rdy[NUM_STG-1] = m_axis_tready;
    for (int k = NUM_STG - 2; k >= 0; k--) begin
      rdy[k]     = !vld_q[k] || rdy[k+1];
      nxt_rdy[k] = rdy[k+1];
    end
  end

  assign s_axis_tready = rdy[STG_ERR];
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign tick_fire     = s_fire && s_axis_tuser[0];
  assign edge_fire     = s_fire && !s_axis_tuser[0];

  always_comb begin
    load[STG_ERR] = tick_fire;
    for (int k = 1; k < NUM_STG; k++) begin
      load[k] = vld_q[k-1] && rdy[k];
    end
    // fill on load, drop when the next stage takes the item
    vld_d = load | (vld_q & ~nxt_rdy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // --------------------------------------------------------------------------
  // Controller state: position, last error, error sum
  // --------------------------------------------------------------------------
  logic [POSITION_BITS-1:0]   pos_q;
  logic signed [ERR_W-1:0]    last_error_q;
  logic signed [SUM_W-1:0]    error_sum_q;

  logic signed [DIFF_W-1:0]   diff;
  logic signed [ERR_W-1:0]    err_sat;

  assign diff = DIFF_W'(target_q) - DIFF_W'($signed(pos_q));

  always_comb begin
    if (diff > ERR_HI) begin
      err_sat = ERR_W'(ERR_HI);
    end else if (diff < ERR_LO) begin
      err_sat = ERR_W'(ERR_LO);
    end else begin
      err_sat = ERR_W'(diff);
    end
  end

  // stage ERR payload
  logic signed [ERR_W-1:0] s1_err_q, s1_last_q;
  logic [OUT_W-1:0]        s1_pos_q;

  always_ff @(posedge clk_i) begin
    if (load[STG_ERR]) begin
      s1_err_q  <= err_sat;
      s1_last_q <= last_error_q;
      s1_pos_q  <= OUT_W'($signed(pos_q));
    end
  end

  // integral update happens as the tick leaves stage ERR, in tick order
  logic signed [SUM_W:0]   sum_wide;
  logic signed [SUM_W-1:0] sum_sat;

  assign sum_wide = (SUM_W+1)'(error_sum_q) + (SUM_W+1)'(s1_err_q);

  always_comb begin
    if (sum_wide > SUM_HI) begin
      sum_sat = SUM_W'(SUM_HI);
    end else if (sum_wide < SUM_LO) begin
      sum_sat = SUM_W'(SUM_LO);
    end else begin
      sum_sat = SUM_W'(sum_wide);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      last_error_q <= '0;
      error_sum_q  <= '0;
    end else begin
      if (edge_fire) begin
        pos_q <= s_axis_tdata[0] ? pos_q + POSITION_BITS'(1)
                                 : pos_q - POSITION_BITS'(1);
      end
      if (tick_fire) begin
        last_error_q <= err_sat;
      end
      if (load[STG_SUM]) begin
        error_sum_q <= sum_sat;
      end
    end
  end

  // stage SUM payload
  logic signed [ERR_W-1:0]   s2_err_q;
  logic signed [DERIV_W-1:0] s2_deriv_q;
  logic signed [SUM_W-1:0]   s2_sum_q;
  logic [OUT_W-1:0]          s2_pos_q;

  always_ff @(posedge clk_i) begin
    if (load[STG_SUM]) begin
      s2_err_q   <= s1_err_q;
      s2_deriv_q <= DERIV_W'(s1_err_q) - DERIV_W'(s1_last_q);
      s2_sum_q   <= sum_sat;
      s2_pos_q   <= s1_pos_q;
    end
  end

  // --------------------------------------------------------------------------
  // Gain products
  // --------------------------------------------------------------------------
  epc_prod_t        prod;
  logic [OUT_W-1:0] s3_pos_q;

  epc_product_stage u_product (
    .clk_i   (clk_i),
    .en_i    (load[STG_PROD]),
    .gains_i (gains_q),
    .err_i   (s2_err_q),
    .deriv_i (s2_deriv_q),
    .sum_i   (s2_sum_q),
    .prod_o  (prod)
  );

  always_ff @(posedge clk_i) begin
    if (load[STG_PROD]) begin
      s3_pos_q <= s2_pos_q;
    end
  end

  // --------------------------------------------------------------------------
  // Accumulate: two pairwise sums, then the full sum
  // --------------------------------------------------------------------------
  logic signed [ACC_W-1:0] s4_a_q, s4_b_q, s5_acc_q;
  logic [OUT_W-1:0]        s4_pos_q, s5_pos_q;

  always_ff @(posedge clk_i) begin
    if (load[STG_PART]) begin
      s4_a_q   <= ACC_W'($signed(prod.p)) + ACC_W'($signed(prod.d));
      s4_b_q   <= (ACC_W'($signed(prod.i_hi)) <<< SUM_LO_W) + ACC_W'($signed(prod.i_lo));
      s4_pos_q <= s3_pos_q;
    end
    if (load[STG_ACC]) begin
      s5_acc_q <= s4_a_q + s4_b_q;
      s5_pos_q <= s4_pos_q;
    end
  end

  // --------------------------------------------------------------------------
  // Scale toward zero, saturate, derive direction and duty
  // --------------------------------------------------------------------------
  logic signed [ACC_W-1:0] scaled;
  logic signed [OUT_W-1:0] ctrl;
  logic [DUTY_W-1:0]       duty;
  logic                    fwd;
  logic [ACC_W-1:0]        neg_scaled;

  // arithmetic shift floors; bump negatives with a dropped fraction back up
  assign scaled = (s5_acc_q >>> GAIN_FRAC_BITS)
                + $signed(ACC_W'(s5_acc_q[ACC_W-1] && ((s5_acc_q & FRAC_MASK) != '0)));
  assign neg_scaled = -scaled;

  always_comb begin
    if (scaled > CTRL_HI) begin
      ctrl = OUT_W'(CTRL_HI);
    end else if (scaled < CTRL_LO) begin
      ctrl = OUT_W'(CTRL_LO);
    end else begin
      ctrl = OUT_W'(scaled);
    end
    if (scaled >= DUTY_HI || scaled <= -DUTY_HI) begin
      duty = DUTY_W'(DUTY_MAX);
    end else if (scaled < 0) begin
      duty = neg_scaled[DUTY_W-1:0];
    end else begin
      duty = scaled[DUTY_W-1:0];
    end
    fwd = (scaled > 0);
  end

  logic [OUT_W-1:0]  out_pos_q, out_ctrl_q;
  logic [DUTY_W-1:0] out_duty_q;
  logic              out_fwd_q;

  always_ff @(posedge clk_i) begin
    if (load[STG_OUT]) begin
      out_duty_q <= duty;
      out_fwd_q  <= fwd;
      out_pos_q  <= s5_pos_q;
      out_ctrl_q <= ctrl;
    end
  end

  assign m_axis_tvalid = vld_q[STG_OUT];
  assign m_axis_tdata  = OUT_TDATA_W'({out_ctrl_q, out_pos_q, out_fwd_q, out_duty_q});

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_edge_steps_one : assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_fire |=> (pos_q == $past(pos_q) + POSITION_BITS'(1)) ||
                  (pos_q == $past(pos_q) - POSITION_BITS'(1)))
    else $error("position moved by other than one step on an encoder edge");

  a_last_error_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tick_fire |=> $stable(last_error_q))
    else $error("last error changed without a control tick");

  a_stall_means_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> vld_q[STG_ERR] && vld_q[STG_OUT] && !m_axis_tready)
    else $error("input stalled while the pipeline could advance");

  a_forward_has_duty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_fwd_q |-> out_duty_q != '0)
    else $error("forward drive reported with zero duty");

endmodule

FILE: tb/sv/encoder_pid_position_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_pid_position_controller_tb
// Self-checking bench for the encoder PID position controller. It starts with
// a directed table of encoder edges, control ticks and register writes, then
// runs random phases under several gain and target settings. It also winds
// the error integral far up and down under the largest integral gain. Every
// control tick runs through a bit-exact model kept in the bench, and directed
// rows with a literal result expect that literal instead. Each result
// transaction is compared field by field with the oldest pending prediction.
// ----------------------------------------------------------------------------
module encoder_pid_position_controller_tb;
  import epc_pkg::*;

  localparam int     HALF_PERIOD   = 10;
  localparam int     SETTLE_CYCLES = 10;
  localparam int     QUIET_LIMIT   = 2000;  // cycles with no transaction at all
  localparam int     LONG_HOLD     = 250;   // receiver hold-off under pressure
  localparam int     MAX_REPORTS   = 32;
  localparam int     WIND_TICKS    = 15;    // ticks of the integral wind-up; the wind-down sends twice as many

  localparam longint I32_MIN   = -(longint'(1) <<< 31);
  localparam longint I32_MAX   = (longint'(1) <<< 31) - 1;
  localparam longint INTEG_MAX = (longint'(1) <<< (SUM_W - 1)) - 1;
  localparam longint INTEG_MIN = -INTEG_MAX - 1;
  localparam longint GAIN_ONE  = longint'(1) <<< GAIN_FRAC_BITS;

  // tuser code of an input transaction
  typedef enum logic {
    KIND_EDGE = 1'b0,
    KIND_TICK = 1'b1
  } item_kind_e;

  // one row of the directed table
  typedef enum logic [1:0] {
    DO_EDGE,
    DO_TICK,
    DO_WRITE
  } step_kind_e;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              fwd;
    logic [OUT_W-1:0]  pos;
    logic [OUT_W-1:0]  ctrl;
  } drive_t;

  typedef struct packed {
    step_kind_e            kind;
    logic                  enc_b;
    cfg_reg_e              reg_idx;
    logic [CFG_DATA_W-1:0] wdata;
    logic                  has_lit;
    drive_t                lit;
  } step_t;

  localparam int DIR_LEN = 37;

  // Literal results are the ones read straight off the control law: the
  // reset gains, the saturated extremes and the zero output.
  step_t directed_steps [DIR_LEN] = '{
    '{DO_TICK,  1'b0, REG_GAIN_P, 32'd0, 1'b1, '{8'd90, 1'b1, 32'd0, 32'd90}},
    '{DO_TICK,  1'b1, REG_GAIN_P, 32'd0, 1'b1, '{8'd90, 1'b1, 32'd0, 32'd90}},
    '{DO_EDGE,  1'b1, REG_GAIN_P, 32'd0, 1'b0, '0},
    '{DO_TICK,  1'b0, REG_GAIN_P, 32'd0, 1'b1, '{8'd89, 1'b1, 32'd1, 32'd89}},
    '{DO_EDGE,  1'b0, REG_GAIN_P, 32'd0, 1'b0, '0},
    '{DO_EDGE,  1'b0, REG_GAIN_P, 32'd0, 1'b0, '0},
    '{DO_TICK,  1'b0, REG_GAIN_P, 32'd0, 1'b1, '{8'd91, 1'b1, 32'hFFFF_FFFF, 32'd91}},
    '{DO_WRITE, 1'b0, REG_TARGET, 32'h8000_0000, 1'b0, '0},
    '{DO_WRITE, 1'b0, REG_GAIN_P, 32'h0000_7FFF, 1'b0, '0},
    '{DO_TICK,  1'b0, REG_GAIN_P, 32'd0, 1'b1,
      '{8'd255, 1'b0, 32'hFFFF_FFFF, 32'h8000_0000}},
    '{DO_EDGE,  1'b1, REG_GAIN_P, 32'd0, 1'b0, '0},
    '{DO_EDGE,  1'b1, REG_GAIN_P, 32'd0, 1'b0, '0},
    '{DO_EDGE,  1'b1, REG_GAIN_P, 32'd0, 1'b0, '0},
    '{DO_WRITE, 1'b0, REG_GAIN_P, 32'hFFFF_8000, 1'b0, '0},
    '{DO_TICK,  1'b0, REG_GAIN_P, 32'd0, 1'b1, '{8'd255, 1'b1, 32'd2, 32'h7FFF_FFFF}},
    '{DO_WRITE, 1'b0, REG_GAIN_P, 32'hABCD_0000, 1'b0, '0},
    '{DO_TICK,  1'b0, REG_GAIN_P, 32'd0, 1'b1, '{8'd0, 1'b0, 32'd2, 32'd0}},
    '{DO_WRITE, 1'b0, REG_GAIN_D, 32'h0000_7FFF, 1'b0, '0},
    '{DO_WRITE, 1'b0, REG_TARGET, 32'h7FFF_FFFF, 1'b0, '0},
    '{DO_TICK,  1'b0, REG_GAIN_P, 32'd0, 1'b0, '0},
    '{DO_WRITE, 1'b0, REG_GAIN_D, 32'h0000_8000, 1'b0, '0},
    '{DO_WRITE, 1'b0, REG_GAIN_I, 32'h0000_0100, 1'b0, '0},
    '{DO_WRITE, 1'b0, REG_GAIN_P, 32'h0000_0001, 1'b0, '0},
    '{DO_TICK,  1'b0, REG_GAIN_P, 32'd0, 1'b0, '0},
    '{DO_EDGE,  1'b0, REG_GAIN_P, 32'd0, 1'b0, '0},
    '{DO_TICK,  1'b0, REG_GAIN_P, 32'd0, 1'b0, '0},
    '{DO_WRITE, 1'b0, REG_GAIN_I, 32'h5A5A_FFFF, 1'b0, '0},
    '{DO_WRITE, 1'b0, REG_TARGET, 32'h0000_0000, 1'b0, '0},
    '{DO_TICK,  1'b0, REG_GAIN_P, 32'd0, 1'b0, '0},
    '{DO_TICK,  1'b1, REG_GAIN_P, 32'd0, 1'b0, '0},
    '{DO_TICK,  1'b0, REG_GAIN_P, 32'd0, 1'b0, '0},
    '{DO_WRITE, 1'b0, REG_GAIN_D, 32'h0000_0040, 1'b0, '0},
    '{DO_WRITE, 1'b0, REG_GAIN_I, 32'h0000_0000, 1'b0, '0},
    '{DO_WRITE, 1'b0, REG_GAIN_P, 32'h0000_0180, 1'b0, '0},
    '{DO_EDGE,  1'b1, REG_GAIN_P, 32'd0, 1'b0, '0},
    '{DO_TICK,  1'b0, REG_GAIN_P, 32'd0, 1'b0, '0},
    '{DO_TICK,  1'b0, REG_GAIN_P, 32'd0, 1'b0, '0}
  };

  // --------------------------------------------------------------------------
  // DUT ports; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  cfg_reg_e               cfg_idx_i     = REG_GAIN_P;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // [0] enc_b, rest zero
  logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;   // [0] kind
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [7:0] pwm_duty, [8] drive_forward, [40:9] position_now, [72:41] control_value
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  encoder_pid_position_controller DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Controller model: position, integral, previous error and the registers
  // --------------------------------------------------------------------------
  logic signed [31:0]     enc_count;
  longint                 err_integral;
  longint                 err_prev;
  logic signed [GAIN_W-1:0] kp_q88, ki_q88, kd_q88;
  logic signed [31:0]     set_point;

  drive_t pending_drive_q [$];
  int     mismatch_cnt = 0;

  // shared with the receiver
  logic   idle_on     = 1'b1;
  int     stall_asked = 0;

  function automatic longint clamp(longint x, longint lo, longint hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  // Run one control tick on the model and return the drive it must produce.
  function automatic drive_t pid_tick_predict();
    longint pos_l, tgt_l, err, deriv, kp, ki, kd, acc, ctrl, mag;
    drive_t r;
    pos_l = enc_count;
    tgt_l = set_point;
    // saturate the error before it feeds the integral and the derivative
    err = clamp(tgt_l - pos_l, I32_MIN, I32_MAX);
    err_integral = clamp(err_integral + err, INTEG_MIN, INTEG_MAX);
    deriv = err - err_prev;
    err_prev = err;
    kp = kp_q88;
    ki = ki_q88;
    kd = kd_q88;
    acc = kp * err + ki * err_integral + kd * deriv;
    // signed division truncates toward zero
    ctrl = clamp(acc / GAIN_ONE, I32_MIN, I32_MAX);
    mag = (ctrl < 0) ? -ctrl : ctrl;
    if (mag > DUTY_MAX) mag = DUTY_MAX;
    r.duty = mag[DUTY_W-1:0];
    r.fwd  = (ctrl > 0);
    r.pos  = enc_count;
    r.ctrl = ctrl[OUT_W-1:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: random hold-off bursts, one long hold on request, result check
  // --------------------------------------------------------------------------
  int rx_gap_left  = 0;
  int rx_long_left = 0;
  int stall_served = 0;

  always @(posedge clk_i) begin
    drive_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got.duty = m_axis_tdata[7:0];
      got.fwd  = m_axis_tdata[8];
      got.pos  = m_axis_tdata[40:9];
      got.ctrl = m_axis_tdata[72:41];
      if (pending_drive_q.size() == 0) begin
        mismatch_cnt <= mismatch_cnt + 1;
        if (mismatch_cnt < MAX_REPORTS)
          $display("%0t: unexpected result transaction, actual %h", $time, got);
      end else begin
        want = pending_drive_q.pop_front();
        if (got != want) begin
          mismatch_cnt <= mismatch_cnt + 1;
          if (mismatch_cnt < MAX_REPORTS) begin
            if (got.duty != want.duty)
              $display("%0t: pwm_duty expected %0d actual %0d",
                       $time, want.duty, got.duty);
            if (got.fwd != want.fwd)
              $display("%0t: drive_forward expected %0d actual %0d",
                       $time, want.fwd, got.fwd);
            if (got.pos != want.pos)
              $display("%0t: position_now expected %0d actual %0d",
                       $time, $signed(want.pos), $signed(got.pos));
            if (got.ctrl != want.ctrl)
              $display("%0t: control_value expected %0d actual %0d",
                       $time, $signed(want.ctrl), $signed(got.ctrl));
          end
        end
      end
    end
    // pick tready for the next cycle
    if (rx_long_left > 0) begin
      m_axis_tready <= 1'b0;
      rx_long_left  <= rx_long_left - 1;
    end else if (stall_served != stall_asked) begin
      // long hold: let the pipeline fill and push back on the input
      stall_served  <= stall_served + 1;
      rx_long_left  <= LONG_HOLD - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_gap_left > 0) begin
      m_axis_tready <= 1'b0;
      rx_gap_left   <= rx_gap_left - 1;
    end else if (idle_on && $urandom_range(0, 6) == 0) begin
      m_axis_tready <= 1'b0;
      rx_gap_left   <= $urandom_range(0, 12);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when nothing moves for too long
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("** encoder_pid_position_controller: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sender side tasks; each one starts and ends right after a rising edge
  // --------------------------------------------------------------------------

  // Offer one input transaction, hold it until accepted, then advance the model.
  task automatic send_item(input item_kind_e kind, input logic enc_b,
                           input logic use_lit, input drive_t lit);
    drive_t r;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {{(IN_TDATA_W-1){1'b0}}, enc_b};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    if (kind == KIND_EDGE) begin
      enc_count = enc_b ? enc_count + 32'sd1 : enc_count - 32'sd1;
    end else begin
      r = pid_tick_predict();
      pending_drive_q.push_back(use_lit ? lit : r);
    end
  endtask

  // Drop valid, wait for all ticks to come out, then let the pipe settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_drive_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write one register; only called while the block is idle.
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      REG_GAIN_P: kp_q88    = data[GAIN_W-1:0];
      REG_GAIN_I: ki_q88    = data[GAIN_W-1:0];
      REG_GAIN_D: kd_q88    = data[GAIN_W-1:0];
      REG_TARGET: set_point = data[TARGET_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Extremes, zero, full random words and small gains that keep outputs linear.
  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    logic [CFG_DATA_W-1:0] v;
    int s;
    v = $urandom();
    s = int'($urandom_range(0, 1200)) - 600;
    case ($urandom_range(0, 6))
      0: v[GAIN_W-1:0] = 16'h8000;
      1: v[GAIN_W-1:0] = 16'h7FFF;
      2: v[GAIN_W-1:0] = 16'h0000;
      3: ;
      default: v[GAIN_W-1:0] = s[GAIN_W-1:0];
    endcase
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_target();
    int off;
    off = int'($urandom_range(0, 400)) - 200;
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom();
      default: return enc_count + off;
    endcase
  endfunction

  // Settle, load a fresh setting, then run a mix of edges and ticks.
  task automatic run_phase(input int n_items, input int tick_pct, input logic idle,
                           input logic pressure);
    drain();
    write_reg(REG_GAIN_P, pick_gain());
    write_reg(REG_GAIN_I, ($urandom_range(0, 2) == 0) ? pick_gain() : 32'd0);
    write_reg(REG_GAIN_D, pick_gain());
    write_reg(REG_TARGET, pick_target());
    idle_on <= idle;
    if (pressure) stall_asked <= stall_asked + 1;
    repeat (n_items) begin
      if ($urandom_range(0, 99) < tick_pct)
        send_item(KIND_TICK, 1'($urandom_range(0, 1)), 1'b0, '0);
      else
        send_item(KIND_EDGE, 1'($urandom_range(0, 1)), 1'b0, '0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic settled;
    step_t st;

    enc_count    = '0;
    err_integral = 0;
    err_prev     = 0;
    kp_q88       = 16'sd256;   // 1.0 after reset
    ki_q88       = '0;
    kd_q88       = '0;
    set_point    = 32'sd90;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table; settle before the first write of each group
    settled = 1'b1;
    for (int k = 0; k < DIR_LEN; k++) begin
      st = directed_steps[k];
      case (st.kind)
        DO_WRITE: begin
          if (!settled) drain();
          settled = 1'b1;
          write_reg(st.reg_idx, st.wdata);
        end
        DO_EDGE: begin
          settled = 1'b0;
          send_item(KIND_EDGE, st.enc_b, 1'b0, '0);
        end
        default: begin
          settled = 1'b0;
          send_item(KIND_TICK, st.enc_b, st.has_lit, st.lit);
        end
      endcase
    end

    // random phases; the third one fills the pipe under a long receiver hold
    for (int ph = 0; ph < 10; ph++)
      run_phase(150, (ph == 2) ? 70 : 10 + 5 * ph, (ph != 5), (ph == 2));

    // wind the integral far up, then far down, under the largest integral gain
    drain();
    idle_on <= 1'b0;
    write_reg(REG_GAIN_P, 32'd0);
    write_reg(REG_GAIN_D, 32'd0);
    write_reg(REG_GAIN_I, 32'h0000_7FFF);
    write_reg(REG_TARGET, 32'h7FFF_FFFF);
    repeat (WIND_TICKS) send_item(KIND_TICK, 1'b0, 1'b0, '0);
    drain();
    write_reg(REG_TARGET, 32'h8000_0000);
    repeat (2 * WIND_TICKS) send_item(KIND_TICK, 1'b1, 1'b0, '0);

    // closing stretch with no idling on either side
    run_phase(120, 30, 1'b0, 1'b0);

    drain();
    if (mismatch_cnt == 0)
      $display("** encoder_pid_position_controller: PASSED **");
    else
      $display("** encoder_pid_position_controller: FAILED **");
    $finish;
  end

endmodule

FILE: sim.f
src/epc_pkg.sv
src/epc_product_stage.sv
src/encoder_pid_position_controller.sv
tb/sv/encoder_pid_position_controller_tb.sv
